FILE: design/kcl_pkg.sv
// Shared types, register indexes and constants for the keypad code lock.
package kcl_pkg;

    localparam int CODE_LEN  = 4;
    localparam int KEY_W     = 8;
    localparam int CNT_W     = 3;
    localparam int FAIL_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 8;

    localparam logic [FAIL_W-1:0] FAIL_MAX = 4'd15;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CODE_KEY_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_KEY_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_KEY_THIRD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_KEY_FOURTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAILURE_LIMIT   = 3'd4;

    localparam logic [KEY_W-1:0]  CODE_KEY_FIRST_RST  = 8'd49;
    localparam logic [KEY_W-1:0]  CODE_KEY_SECOND_RST = 8'd50;
    localparam logic [KEY_W-1:0]  CODE_KEY_THIRD_RST  = 8'd51;
    localparam logic [KEY_W-1:0]  CODE_KEY_FOURTH_RST = 8'd52;
    localparam logic [FAIL_W-1:0] FAILURE_LIMIT_RST   = 4'd3;

    typedef enum logic [1:0] {
        MODE_LOCKED   = 2'd0,
        MODE_UNLOCKED = 2'd1,
        MODE_ALARM    = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ACT_KEY       = 2'd0,
        ACT_LOCK      = 2'd1,
        ACT_BELL      = 2'd2,
        ACT_EMERGENCY = 2'd3
    } action_t;

    typedef struct packed {
        mode_t             lock_mode;
        logic [CNT_W-1:0]  progress_count;
        logic              success_lamp;
        logic              alarm_lamp;
        logic              locked_lamp;
        logic [FAIL_W-1:0] failure_count;
        logic              doorbell_pulse;
    } result_t;

endpackage

FILE: design/kcl_cell.sv
// Key cell: holds one entered key, passes it on, and extends the match chain.
module kcl_cell
    import kcl_pkg::*;
(
    input  logic             clk,
    input  logic             shift_en,
    input  logic [KEY_W-1:0] key_in,
    input  logic [KEY_W-1:0] code_key,
    input  logic             match_in,
    output logic [KEY_W-1:0] key_out,
    output logic             match_out
);

    logic [KEY_W-1:0] key_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            key_reg <= key_in;
        end
    end

    assign key_out   = key_reg;
    assign match_out = match_in & (key_reg == code_key);

endmodule

FILE: design/kcl_ctrl.sv
// Mode state machine with key count and failure count of the lock.
module kcl_ctrl
    import kcl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  action_t           action,
    input  logic              code_match,
    input  logic [FAIL_W-1:0] failure_limit,
    output logic              shift_en,
    output result_t           res_next
);

    mode_t             mode_reg,  mode_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [FAIL_W-1:0] fail_reg,  fail_next;
    logic [FAIL_W-1:0] fail_inc;
    logic              bell;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_LOCKED;
            count_reg <= '0;
            fail_reg  <= '0;
        end
        else if (in_fire)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            fail_reg  <= fail_next;
        end
    end

    // Saturate the failure count at its top value
    assign fail_inc = (fail_reg != FAIL_MAX) ? fail_reg + 1'b1 : fail_reg;

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        fail_next  = fail_reg;
        bell       = 1'b0;
        shift_en   = 1'b0;
        case (action)
            ACT_EMERGENCY:
            begin
                fail_next  = '0;
                count_next = '0;
                mode_next  = MODE_LOCKED;
            end
            ACT_BELL:
            begin
                bell = 1'b1;
            end
            ACT_LOCK:
            begin
                if (mode_reg == MODE_UNLOCKED)
                begin
                    count_next = '0;
                    mode_next  = MODE_LOCKED;
                end
            end
            ACT_KEY:
            begin
                if (mode_reg == MODE_LOCKED)
                begin
                    shift_en = in_fire;
                    if (count_reg == CNT_W'(CODE_LEN - 1))
                    begin
                        // Last key: check the whole attempt and reset the key count
                        count_next = '0;
                        if (code_match)
                        begin
                            fail_next = '0;
                            mode_next = MODE_UNLOCKED;
                        end
                        else
                        begin
                            fail_next = fail_inc;
                            if (fail_inc >= failure_limit)
                            begin
                                mode_next = MODE_ALARM;
                            end
                        end
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        res_next.lock_mode      = mode_next;
        res_next.progress_count = count_next;
        res_next.success_lamp   = (mode_next == MODE_UNLOCKED);
        res_next.alarm_lamp     = (mode_next == MODE_ALARM);
        res_next.locked_lamp    = (mode_next == MODE_LOCKED);
        res_next.failure_count  = fail_next;
        res_next.doorbell_pulse = bell;
    end

endmodule

FILE: design/keypad_code_lock_controller_core.sv
// Keypad code lock: key cell chain, mode control and output register.
// Each result beat is registered and is offered in the cycle after its input beat.
// Throughput: one beat per cycle; the single output register stalls input only while
// its result is held by the downstream side.
// Reset: rst_n clears mode to locked, key and failure counts to zero and
// restores the default unlock code and failure limit.
module keypad_code_lock_controller_core
    import kcl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // key_code[7:0]
    input  logic [1:0]           s_tuser,   // action[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // lock_mode[1:0], progress_count[4:2], success_lamp[5], alarm_lamp[6],
    // locked_lamp[7], failure_count[11:8], doorbell_pulse[12], zero fill[15:13]
    output logic [15:0]          m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [KEY_W-1:0]  code_key_reg [CODE_LEN];
    logic [FAIL_W-1:0] failure_limit_reg;

    logic              in_fire;
    logic              shift_en;
    logic              code_match;
    result_t           res_next;
    result_t           out_data_reg;
    logic              out_valid_reg;

    logic [KEY_W-1:0]  chain_key   [CODE_LEN];
    logic              chain_match [CODE_LEN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_key_reg[0]   <= CODE_KEY_FIRST_RST;
            code_key_reg[1]   <= CODE_KEY_SECOND_RST;
            code_key_reg[2]   <= CODE_KEY_THIRD_RST;
            code_key_reg[3]   <= CODE_KEY_FOURTH_RST;
            failure_limit_reg <= FAILURE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CODE_KEY_FIRST:  code_key_reg[0]   <= cfg_data;
                REG_CODE_KEY_SECOND: code_key_reg[1]   <= cfg_data;
                REG_CODE_KEY_THIRD:  code_key_reg[2]   <= cfg_data;
                REG_CODE_KEY_FOURTH: code_key_reg[3]   <= cfg_data;
                REG_FAILURE_LIMIT:   failure_limit_reg <= cfg_data[FAIL_W-1:0];
                default:             failure_limit_reg <= failure_limit_reg;
            endcase
        end
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // The incoming key is checked against the last code key; the cells hold the
    // earlier keys, newest first, and check them against the earlier code keys.
    assign chain_key[0]   = s_tdata[KEY_W-1:0];
    assign chain_match[0] = (s_tdata[KEY_W-1:0] == code_key_reg[CODE_LEN-1]);

    for (genvar i = 0; i < CODE_LEN - 1; i++)
    begin : g_cell
        kcl_cell u_cell (
            .clk       (clk),
            .shift_en  (shift_en),
            .key_in    (chain_key[i]),
            .code_key  (code_key_reg[CODE_LEN-2-i]),
            .match_in  (chain_match[i]),
            .key_out   (chain_key[i+1]),
            .match_out (chain_match[i+1])
        );
    end

    assign code_match = chain_match[CODE_LEN-1];

    kcl_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .action        (action_t'(s_tuser)),
        .code_match    (code_match),
        .failure_limit (failure_limit_reg),
        .shift_en      (shift_en),
        .res_next      (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the result beat until it is taken
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_data_reg.doorbell_pulse,
                       out_data_reg.failure_count,
                       out_data_reg.locked_lamp,
                       out_data_reg.alarm_lamp,
                       out_data_reg.success_lamp,
                       out_data_reg.progress_count,
                       out_data_reg.lock_mode};

endmodule
